@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker module.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define SBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define SBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sbm_pkg.sv @@
// Shared types and constants of the serial bank mapper.
// No dependencies; used by the top level and its checker.
`default_nettype none

package sbm_pkg;

  localparam int unsigned ShiftBits = 5;
  localparam int unsigned CountW    = $clog2(ShiftBits + 1);
  localparam int unsigned AddrW     = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned CfgDataW  = 5;
  localparam int unsigned PrgW      = 4;
  localparam int unsigned ChrW      = 5;
  localparam int unsigned MirW      = 2;

  // Target register selected by address bits 14-13.
  typedef enum logic [1:0] {
    SEL_CONTROL = 2'd0,
    SEL_CHR0    = 2'd1,
    SEL_CHR1    = 2'd2,
    SEL_PRG     = 2'd3
  } reg_sel_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_PRG_BANK_COUNT = 1'b0,
    CFG_CHR_ROM_PRESENT = 1'b1
  } cfg_idx_e;

  // Mirroring codes.
  localparam logic [MirW-1:0] MirOneScreen = 2'd0;
  localparam logic [MirW-1:0] MirVertical  = 2'd1;
  localparam logic [MirW-1:0] MirHorizontal = 2'd2;
  localparam logic [MirW-1:0] MirUnset     = 2'd3;

  localparam logic [ShiftBits-1:0] CtrlResetVal = 5'h0C;
  localparam logic [CfgDataW-1:0]  PrgCountResetVal = 5'd16;

  // Bank map after reset, as the outputs show it.
  localparam logic [PrgW-1:0] PrgLowResetVal  = 4'd0;
  localparam logic [PrgW-1:0] PrgHighResetVal = 4'hF;
  localparam logic [ChrW-1:0] ChrLowResetVal  = 5'd0;
  localparam logic [ChrW-1:0] ChrHighResetVal = 5'd1;

endpackage

`default_nettype wire

@@ hw/rtl/serial_bank_mapper_unit.sv @@
// Serial-load cartridge bank mapper: shifter, control state and bank map.
// Depends on sbm_pkg.
`default_nettype none

// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one CPU write to cartridge
//   space: cpu_address_i and write_data_i. Output channel (out_valid_o /
//   out_stall_i) returns one item per write with the bank map as it stands
//   after that write, plus register_loaded_o when the write finished a
//   five-bit load. An item moves when valid is high and stall is low.
//   Configuration (cfg_valid_i / cfg_ready_o, always ready) sets the program
//   bank count (index 0) and pattern ROM presence (index 1); write it only
//   while no item is in flight.
//   Path: input register, then the state update that loads the result register.
//   Throughput: one item per cycle while the output is not stalled.
//   Reset: shifter empty, control 0x0C, map low/high program banks 0/15,
//   pattern banks 0/1, mirroring not yet set, both channels empty.
//   A stalled result holds, and the input register then fills and raises
//   in_stall_o until the result is taken.
module serial_bank_mapper_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [sbm_pkg::AddrW-1:0]     cpu_address_i,
  input  wire logic [sbm_pkg::DataW-1:0]     write_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [sbm_pkg::PrgW-1:0]           prg_low_bank_o,
  output logic [sbm_pkg::PrgW-1:0]           prg_high_bank_o,
  output logic [sbm_pkg::ChrW-1:0]           chr_low_bank_o,
  output logic [sbm_pkg::ChrW-1:0]           chr_high_bank_o,
  output logic [sbm_pkg::MirW-1:0]           mirroring_o,
  output logic                               register_loaded_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [sbm_pkg::CfgDataW-1:0]  cfg_data_i
);
  import sbm_pkg::*;

  // Configuration
  logic [CfgDataW-1:0] prg_count_q;
  logic                chr_present_q;

  // Input register
  logic     in_valid_q;
  reg_sel_e sel_q;
  logic     clr_bit_q;
  logic     ser_bit_q;

  // Mapper state; the map registers also drive the outputs
  logic [ShiftBits-1:0] shift_q, shift_d;
  logic [CountW-1:0]    count_q, count_d;
  logic [ShiftBits-1:0] ctrl_q, ctrl_d;
  logic [PrgW-1:0]      prg_lo_q, prg_lo_d, prg_hi_q, prg_hi_d;
  logic [ChrW-1:0]      chr_lo_q, chr_lo_d, chr_hi_q, chr_hi_d;
  logic [MirW-1:0]      mir_q, mir_d;
  logic                 loaded_q, loaded_d;
  logic                 out_valid_q;

  logic                 out_free;
  logic                 advance;
  logic [ShiftBits-1:0] value;
  logic [CountW-1:0]    count_inc;
  logic [PrgW-1:0]      mask;
  logic [PrgW-1:0]      bank;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q   <= PrgCountResetVal;
      chr_present_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PRG_BANK_COUNT:  prg_count_q   <= cfg_data_i;
        CFG_CHR_ROM_PRESENT: chr_present_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Keep only the address and data bits the mapper looks at
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      sel_q     <= reg_sel_e'(cpu_address_i[14:13]);
      clr_bit_q <= write_data_i[7];
      ser_bit_q <= write_data_i[0];
    end
  end

  always_comb begin
    shift_d   = shift_q;
    count_d   = count_q;
    ctrl_d    = ctrl_q;
    prg_lo_d  = prg_lo_q;
    prg_hi_d  = prg_hi_q;
    chr_lo_d  = chr_lo_q;
    chr_hi_d  = chr_hi_q;
    mir_d     = mir_q;
    loaded_d  = 1'b0;
    count_inc = count_q + CountW'(1);
    value     = shift_q | (ShiftBits'(ser_bit_q) << count_q);
    mask      = PrgW'(prg_count_q - CfgDataW'(1));
    bank      = value[PrgW-1:0] & mask;

    if (clr_bit_q) begin
      shift_d = '0;
      count_d = '0;
      ctrl_d  = ctrl_q | CtrlResetVal;
    end else if (count_inc < CountW'(ShiftBits)) begin
      shift_d = value;
      count_d = count_inc;
    end else begin
      // Fifth bit: load the selected register
      shift_d  = '0;
      count_d  = '0;
      loaded_d = 1'b1;
      case (sel_q)
        SEL_CONTROL: begin
          ctrl_d = value;
          if (value[1]) begin
            mir_d = value[0] ? MirHorizontal : MirVertical;
          end else begin
            mir_d = MirOneScreen;
          end
        end
        SEL_CHR0: begin
          if (chr_present_q) begin
            if (ctrl_q[4]) begin
              chr_lo_d = value;
            end else begin
              chr_lo_d = {value[ChrW-1:1], 1'b0};
              chr_hi_d = {value[ChrW-1:1], 1'b1};
            end
          end
        end
        SEL_CHR1: begin
          if (chr_present_q && ctrl_q[4]) begin
            chr_hi_d = value;
          end
        end
        SEL_PRG: begin
          if (ctrl_q[3]) begin
            if (ctrl_q[2]) begin
              prg_lo_d = bank;
              prg_hi_d = mask;
            end else begin
              prg_lo_d = '0;
              prg_hi_d = bank;
            end
          end else begin
            // 32k mode maps an even/odd pair
            prg_lo_d = {bank[PrgW-1:1], 1'b0};
            prg_hi_d = {bank[PrgW-1:1], 1'b1} & mask;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= '0;
      count_q  <= '0;
      ctrl_q   <= CtrlResetVal;
      prg_lo_q <= PrgLowResetVal;
      prg_hi_q <= PrgHighResetVal;
      chr_lo_q <= ChrLowResetVal;
      chr_hi_q <= ChrHighResetVal;
      mir_q    <= MirUnset;
      loaded_q <= 1'b0;
    end else if (advance) begin
      shift_q  <= shift_d;
      count_q  <= count_d;
      ctrl_q   <= ctrl_d;
      prg_lo_q <= prg_lo_d;
      prg_hi_q <= prg_hi_d;
      chr_lo_q <= chr_lo_d;
      chr_hi_q <= chr_hi_d;
      mir_q    <= mir_d;
      loaded_q <= loaded_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign prg_low_bank_o    = prg_lo_q;
  assign prg_high_bank_o   = prg_hi_q;
  assign chr_low_bank_o    = chr_lo_q;
  assign chr_high_bank_o   = chr_hi_q;
  assign mirroring_o       = mir_q;
  assign register_loaded_o = loaded_q;

endmodule

`default_nettype wire

@@ hw/rtl/sbm_checker.sv @@
// Port-level checker for the serial bank mapper, bound to the top level.
// Depends on sbm_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module sbm_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_stall_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic [sbm_pkg::PrgW-1:0]  prg_low_bank_o,
  input wire logic [sbm_pkg::PrgW-1:0]  prg_high_bank_o,
  input wire logic [sbm_pkg::ChrW-1:0]  chr_low_bank_o,
  input wire logic [sbm_pkg::ChrW-1:0]  chr_high_bank_o,
  input wire logic [sbm_pkg::MirW-1:0]  mirroring_o,
  input wire logic                      register_loaded_o
);
  import sbm_pkg::*;

  logic            out_acc;
  logic            prev_loaded_q;
  logic [PrgW-1:0] prg_lo_q, prg_hi_q;
  logic [ChrW-1:0] chr_lo_q, chr_hi_q;
  logic [MirW-1:0] mir_q;
  logic            same_map;

  assign out_acc  = out_valid_o && !out_stall_i;
  assign same_map = (prg_low_bank_o == prg_lo_q) && (prg_high_bank_o == prg_hi_q)
                 && (chr_low_bank_o == chr_lo_q) && (chr_high_bank_o == chr_hi_q)
                 && (mirroring_o == mir_q);

  // Track the last delivered item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_loaded_q <= 1'b0;
      prg_lo_q      <= PrgLowResetVal;
      prg_hi_q      <= PrgHighResetVal;
      chr_lo_q      <= ChrLowResetVal;
      chr_hi_q      <= ChrHighResetVal;
      mir_q         <= MirUnset;
    end else if (out_acc) begin
      prev_loaded_q <= register_loaded_o;
      prg_lo_q      <= prg_low_bank_o;
      prg_hi_q      <= prg_high_bank_o;
      chr_lo_q      <= chr_low_bank_o;
      chr_hi_q      <= chr_high_bank_o;
      mir_q         <= mirroring_o;
    end
  end

  `SBM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped")
  `SBM_ASSERT_IMP(a_in_free, !out_valid_o, !in_stall_o, "input stalled with empty output")
  `SBM_ASSERT_IMP(a_load_gap, out_acc && register_loaded_o, !prev_loaded_q, "loads too close")
  `SBM_ASSERT_IMP(a_map_kept, out_acc && !register_loaded_o, same_map, "map changed without load")

endmodule

bind serial_bank_mapper_unit sbm_checker u_sbm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .prg_low_bank_o    (prg_low_bank_o),
  .prg_high_bank_o   (prg_high_bank_o),
  .chr_low_bank_o    (chr_low_bank_o),
  .chr_high_bank_o   (chr_high_bank_o),
  .mirroring_o       (mirroring_o),
  .register_loaded_o (register_loaded_o)
);

`default_nettype wire
